FILE: rtl/core/dds_pkg.sv
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types, register map, shape codes and sine polynomial coefficients
// for the direct digital synthesis waveform generator.
// ----------------------------------------------------------------------------
package dds_pkg;

	localparam int DEF_PHASE_BITS      = 32;
	localparam int DEF_SINE_TABLE_BITS = 10;
	localparam int DEF_DAC_BITS        = 8;

	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SHAPE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_PERCENT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DC_OFFSET    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_START_PHASE  = 3'd5;

	// wave shapes
	localparam logic [2:0] SHAPE_SINE     = 3'd0;
	localparam logic [2:0] SHAPE_SQUARE   = 3'd1;
	localparam logic [2:0] SHAPE_TRIANGLE = 3'd2;
	localparam logic [2:0] SHAPE_SAWTOOTH = 3'd3;
	localparam logic [2:0] SHAPE_NOISE    = 3'd4;
	localparam logic [2:0] SHAPE_PULSE    = 3'd5;

	localparam logic [6:0]  DUTY_RESET = 7'd50;
	localparam logic [6:0]  DUTY_MAX   = 7'd100;
	localparam logic [15:0] AMP_RESET  = 16'd4096;

	// counter value of the last horner subtract step after the seed coefficient
	localparam logic [2:0] HORNER_LAST = 3'd4;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_PREP  = 11'b000_0000_0010,
		ST_SQ    = 11'b000_0000_0100,
		ST_X2    = 11'b000_0000_1000,
		ST_HMUL  = 11'b000_0001_0000,
		ST_HSUB  = 11'b000_0010_0000,
		ST_MAG   = 11'b000_0100_0000,
		ST_RND   = 11'b000_1000_0000,
		ST_SCALE = 11'b001_0000_0000,
		ST_LVL   = 11'b010_0000_0000,
		ST_EMIT  = 11'b100_0000_0000
	} dds_state_t;

	// q30 odd polynomial for sin(pi/2*x), highest order first
	function automatic logic [30:0] sin_coef(input logic [2:0] k);
		logic [30:0] c;
		case (k)
			3'd0:    c = 31'd3864;
			3'd1:    c = 31'd172272;
			3'd2:    c = 31'd5026994;
			3'd3:    c = 31'd85569306;
			3'd4:    c = 31'd693598670;
			3'd5:    c = 31'd1686629713;
			default: c = 31'd0;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/core/dds_waveform_generator_top.sv
// ----------------------------------------------------------------------------
// dds_waveform_generator_top
// Phase accumulator waveform generator with gain, offset and saturating
// converter code output.
// ----------------------------------------------------------------------------
// Each accepted transaction is one sample tick. The block is busy until the
// result is loaded into the output register, and a sine tick keeps it busy
// longer than any other shape, because one 32x32 multiplier is reused for
// the sine polynomial (squaring, five horner steps, final product) and for
// the gain. The result sits in an output register, so a stalled result does
// not hold up the next tick's work, only its delivery. Configuration writes
// take effect at once and are meant for idle periods.
module dds_waveform_generator_top
	import dds_pkg::*;
#(
	parameter int PHASE_BITS      = DEF_PHASE_BITS,
	parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS,
	parameter int DAC_BITS        = DEF_DAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   restart,
	input  logic [15:0]            noise_word,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [DAC_BITS-1:0]    dac_code,
	output logic signed [15:0]     raw_sample
);

	localparam int QB     = SINE_TABLE_BITS - 2;
	localparam int WIDE_W = 33 + DAC_BITS;
	localparam logic [DAC_BITS+3:0] DAC_MAX = (DAC_BITS+4)'((1 << DAC_BITS) - 1);

	// configuration registers
	logic [2:0]         shape_q;
	logic [31:0]        step_q;
	logic [6:0]         duty_q;
	logic [15:0]        amp_q;
	logic signed [15:0] offset_q;
	logic [31:0]        start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q  <= SHAPE_SINE;
			step_q   <= '0;
			duty_q   <= DUTY_RESET;
			amp_q    <= AMP_RESET;
			offset_q <= '0;
			start_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WAVE_SHAPE:   shape_q  <= cfg_data[2:0];
				REG_PHASE_STEP:   step_q   <= cfg_data;
				REG_DUTY_PERCENT: duty_q   <= cfg_data[6:0];
				REG_AMPLITUDE:    amp_q    <= cfg_data[15:0];
				REG_DC_OFFSET:    offset_q <= signed'(cfg_data[15:0]);
				REG_START_PHASE:  start_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// align a 32-bit cycle fraction to the accumulator width
	function automatic logic [PHASE_BITS-1:0] align_phase(input logic [31:0] v);
		logic [PHASE_BITS+31:0] t;
		t = (PHASE_BITS+32)'(v);
		t = (t << PHASE_BITS) >> 32;
		return t[PHASE_BITS-1:0];
	endfunction

	dds_state_t state_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [15:0]           noise_q;
	logic [2:0]            cnt_q;
	logic [1:0]            quarter_q;
	logic [30:0]           x_q;
	logic [30:0]           x2_q;
	logic [30:0]           s_q;
	logic signed [16:0]    samp_q;
	logic signed [33:0]    level_q;
	logic [63:0]           prod_q;

	logic accept_in;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept_in = in_valid && !in_stall;

	// shared multiplier
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [16:0] samp_abs;
	assign samp_abs = samp_q[16] ? 17'(-samp_q) : 17'(samp_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQ: begin
				mul_a = 32'(x_q);
				mul_b = 32'(x_q);
			end
			ST_HMUL: begin
				mul_a = 32'(s_q);
				mul_b = 32'(x2_q);
			end
			ST_MAG: begin
				mul_a = 32'(s_q);
				mul_b = 32'(x_q);
			end
			ST_SCALE: begin
				mul_a = 32'(samp_abs);
				mul_b = 32'(amp_q);
			end
			default: ;
		endcase
	end

	// per-tick decode of the phase
	logic [15:0]                p16;
	logic [SINE_TABLE_BITS-1:0] sin_idx;
	logic [QB:0]                r_fold;
	logic [6:0]                 duty_eff;
	logic [PHASE_BITS+6:0]      phase_x100;
	logic [PHASE_BITS+6:0]      duty_thr;
	logic                       high_part;
	logic signed [17:0]         tri_val;
	logic signed [16:0]         shape_val;

	assign p16      = phase_q[PHASE_BITS-1 -: 16];
	assign sin_idx  = phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
	assign r_fold   = sin_idx[QB] ? ((QB+1)'(1) << QB) - (QB+1)'(sin_idx[QB-1:0])
	                              : (QB+1)'(sin_idx[QB-1:0]);
	assign duty_eff = (duty_q > DUTY_MAX) ? DUTY_MAX : duty_q;

	// acc * 100 by shifts and adds
	assign phase_x100 = ((PHASE_BITS+7)'(phase_q) << 6) + ((PHASE_BITS+7)'(phase_q) << 5)
	                  + ((PHASE_BITS+7)'(phase_q) << 2);
	assign duty_thr   = (PHASE_BITS+7)'(duty_eff) << PHASE_BITS;
	assign high_part  = phase_x100 < duty_thr;

	assign tri_val = p16[15] ? 18'sd98304 - signed'({1'b0, p16, 1'b0})
	                         : signed'({1'b0, p16, 1'b0}) - 18'sd32768;

	always_comb begin
		case (shape_q)
			SHAPE_SQUARE:   shape_val = high_part ? 17'sd32768 : -17'sd32768;
			SHAPE_TRIANGLE: shape_val = tri_val[16:0];
			SHAPE_SAWTOOTH: shape_val = signed'({1'b0, p16}) - 17'sd32768;
			SHAPE_NOISE:    shape_val = signed'({1'b0, noise_q}) - 17'sd32768;
			SHAPE_PULSE:    shape_val = high_part ? 17'sd32768 : 17'sd0;
			default:        shape_val = 17'sd0;
		endcase
	end

	// sine rounding
	logic [34:0] mag_rnd;
	logic [19:0] mag_q15;
	logic [16:0] mag_sat;
	assign mag_rnd = 35'(prod_q[63:30]) + 35'd16384;
	assign mag_q15 = mag_rnd[34:15];
	assign mag_sat = (mag_q15 > 20'd32768) ? 17'd32768 : mag_q15[16:0];

	// converter code from level
	logic [WIDE_W-1:0]   lv_wide;
	logic [WIDE_W-1:0]   scaled;
	logic [DAC_BITS+3:0] code_raw;
	logic [DAC_BITS-1:0] code;
	assign lv_wide  = WIDE_W'(level_q[32:0]);
	assign scaled   = (lv_wide << DAC_BITS) - lv_wide;
	assign code_raw = scaled[WIDE_W-1:29];
	always_comb begin
		if (level_q[33] || level_q == '0)
			code = '0;
		else if (code_raw > DAC_MAX)
			code = DAC_MAX[DAC_BITS-1:0];
		else
			code = code_raw[DAC_BITS-1:0];
	end

	logic emit_ok;
	assign emit_ok = !out_valid || !out_stall;

	// result valid: set when a result is loaded, cleared once it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (state_q == ST_EMIT && emit_ok)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= '0;
			cnt_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						if (restart)
							phase_q <= align_phase(start_q);
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					phase_q <= phase_q + align_phase(step_q);
					state_q <= (shape_q == SHAPE_SINE) ? ST_SQ : ST_SCALE;
				end
				ST_SQ:   state_q <= ST_X2;
				ST_X2: begin
					cnt_q   <= '0;
					state_q <= ST_HMUL;
				end
				ST_HMUL: state_q <= ST_HSUB;
				ST_HSUB: begin
					cnt_q   <= cnt_q + 3'd1;
					state_q <= (cnt_q == HORNER_LAST) ? ST_MAG : ST_HMUL;
				end
				ST_MAG:   state_q <= ST_RND;
				ST_RND:   state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_LVL;
				ST_LVL:   state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit_ok)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		if (accept_in)
			noise_q <= noise_word;
		case (state_q)
			ST_PREP: begin
				quarter_q <= sin_idx[SINE_TABLE_BITS-1 -: 2];
				x_q       <= 31'(r_fold) << (30 - QB);
				samp_q    <= shape_val;
			end
			ST_X2: begin
				x2_q <= prod_q[60:30];
				s_q  <= sin_coef(3'd0);
			end
			ST_HSUB: s_q <= sin_coef(cnt_q + 3'd1) - prod_q[60:30];
			ST_RND:  samp_q <= quarter_q[1] ? -signed'(mag_sat) : signed'(mag_sat);
			ST_LVL: begin
				level_q <= (samp_q[16] ? -signed'(34'(prod_q[31:0]))
				                       : signed'(34'(prod_q[31:0])))
				         + (34'(offset_q) <<< 16) + 34'sd268435456;
			end
			ST_EMIT: begin
				if (emit_ok) begin
					dac_code   <= code;
					raw_sample <= (samp_q > 17'sd32767) ? 16'sd32767 : samp_q[15:0];
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dds waveform generator. A scoreboard class
// tracks registers and phase and computes the sample and converter code for
// every accepted tick. It first runs a directed pass over shapes, saturation
// limits and odd register values, then random settings with random idling
// on both handshakes, a long receiver hold and sender pauses.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dds_pkg::*;

	// codes the block treats as unused
	localparam logic [2:0]             SHAPE_UNDEF_A = 3'd6;
	localparam logic [2:0]             SHAPE_UNDEF_B = 3'd7;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

	localparam int DIRECTED_TICKS = 24;
	localparam int RANDOM_TICKS   = 1400;
	localparam int LONG_HOLD      = 200;
	localparam int TAIL_CYCLES    = 40;

	typedef struct {
		logic [7:0]         dac;
		logic signed [15:0] raw;
	} dds_sample_t;

	class dds_scoreboard;
		logic [2:0]         wave;
		logic [31:0]        incr;
		logic [6:0]         duty;
		logic [15:0]        gain;
		logic signed [15:0] offset;
		logic [31:0]        phase_start;
		logic [31:0]        phase;
		dds_sample_t        expected_q[$];
		int ticks, checked, errors;

		function new();
			wave        = SHAPE_SINE;
			incr        = '0;
			duty        = DUTY_RESET;
			gain        = AMP_RESET;
			offset      = '0;
			phase_start = '0;
			phase       = '0;
			ticks       = 0;
			checked     = 0;
			errors      = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_WAVE_SHAPE:   wave        = data[2:0];
				REG_PHASE_STEP:   incr        = data;
				REG_DUTY_PERCENT: duty        = data[6:0];
				REG_AMPLITUDE:    gain        = data[15:0];
				REG_DC_OFFSET:    offset      = data[15:0];
				REG_START_PHASE:  phase_start = data;
				default: ;
			endcase
		endfunction

		// signed sine sample from the q30 polynomial on a folded quarter wave, rounded to q15
		function int sine_value(logic [9:0] idx);
			logic [8:0]  r;
			logic [63:0] x, x2, acc, mag;
			r = {1'b0, idx[7:0]};
			if (idx[8])
				r = 9'd256 - r;
			x   = 64'(r) << 22;
			x2  = (x * x) >> 30;
			acc = 64'd3864;
			acc = 64'd172272 - ((acc * x2) >> 30);
			acc = 64'd5026994 - ((acc * x2) >> 30);
			acc = 64'd85569306 - ((acc * x2) >> 30);
			acc = 64'd693598670 - ((acc * x2) >> 30);
			acc = 64'd1686629713 - ((acc * x2) >> 30);
			mag = (acc * x) >> 30;
			mag = (mag + 64'd16384) >> 15;
			if (mag > 64'd32768)
				mag = 64'd32768;
			return idx[9] ? -int'(mag) : int'(mag);
		endfunction

		function void accept_tick(bit rs, logic [15:0] nw);
			int          s;
			longint      lvl, code;
			logic [15:0] p16;
			logic [6:0]  d;
			bit          high;
			dds_sample_t e;
			if (rs)
				phase = phase_start;
			p16  = phase[31:16];
			d    = (duty > DUTY_MAX) ? DUTY_MAX : duty;
			high = (64'(phase) * 100) < (64'(d) << 32);
			case (wave)
				SHAPE_SINE:     s = sine_value(phase[31:22]);
				SHAPE_SQUARE:   s = high ? 32768 : -32768;
				SHAPE_TRIANGLE: s = (p16 < 16'h8000) ? 2 * int'(p16) - 32768
				                                    : 98304 - 2 * int'(p16);
				SHAPE_SAWTOOTH: s = int'(p16) - 32768;
				SHAPE_NOISE:    s = int'(nw) - 32768;
				SHAPE_PULSE:    s = high ? 32768 : 0;
				default:        s = 0;
			endcase
			lvl = longint'(s) * longint'(gain) + longint'(offset) * 65536
			      + (longint'(1) << 28);
			if (lvl <= 0) begin
				code = 0;
			end else begin
				code = (lvl * 255) >>> 29;
				if (code > 255)
					code = 255;
			end
			e.dac = code[7:0];
			e.raw = 16'((s > 32767) ? 32767 : s);
			expected_q.push_back(e);
			phase = phase + incr;
			ticks++;
		endfunction

		function void check_sample(logic [7:0] dac, logic signed [15:0] raw);
			dds_sample_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result with no pending tick: dac %0d raw %0d", dac, raw);
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (dac !== e.dac || raw !== e.raw) begin
				errors++;
				if (errors <= 10)
					$display("sample %0d: expected dac %0d raw %0d, got dac %0d raw %0d",
						checked, e.dac, e.raw, dac, raw);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic                   restart;
	logic [15:0]            noise_word;
	logic                   out_valid;
	logic                   out_stall;
	logic [7:0]             dac_code;
	logic signed [15:0]     raw_sample;

	dds_scoreboard sb;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit long_hold_req = 1'b0;
	int n_settings = 0;
	int n_holds = 0;
	int n_pauses = 0;

	dds_waveform_generator_top dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// upper data bits carry junk, the block must mask them
	task automatic configure(input logic [2:0] shape, input logic [31:0] step,
		input logic [6:0] duty, input logic [15:0] amp, input logic [15:0] off,
		input logic [31:0] start, input bit stray);
		logic [31:0] junk;
		junk = $urandom();
		write_reg(REG_WAVE_SHAPE, {junk[31:3], shape});
		write_reg(REG_PHASE_STEP, step);
		write_reg(REG_DUTY_PERCENT, {junk[31:7], duty});
		write_reg(REG_AMPLITUDE, {junk[31:16], amp});
		write_reg(REG_DC_OFFSET, {junk[15:0], off});
		write_reg(REG_START_PHASE, start);
		if (stray)
			write_reg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO, $urandom());
		cfg_write <= 1'b0;
		n_settings++;
	endtask

	// valid stays high into the next call when no gap is drawn
	task automatic send_tick(input bit rs, input logic [15:0] nw);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		restart    <= rs;
		noise_word <= nw;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.accept_tick(rs, nw);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
	endtask

	task automatic burst(input int count, input bit first_restart, input int pause_at);
		int          i;
		bit          rs;
		logic [15:0] nw;
		for (i = 0; i < count; i++) begin
			if (i == pause_at) begin
				settle();
				n_pauses++;
			end
			rs = (i == 0) ? first_restart : ($urandom_range(0, 7) == 0);
			case ($urandom_range(0, 15))
				0:       nw = 16'h0000;
				1:       nw = 16'hFFFF;
				default: nw = 16'($urandom());
			endcase
			send_tick(rs, nw);
		end
		settle();
	endtask

	// result side: random stall before each transaction, long hold on request
	initial begin : result_sink
		int n;
		wait (arst_n === 1'b1);
		forever begin
			n = rx_idle_on ? $urandom_range(0, 10) : 0;
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				n = LONG_HOLD;
				n_holds++;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_sample(dac_code, raw_sample);
		end
	end

	initial begin : stimulus
		logic [2:0]  shape;
		logic [31:0] step, start;
		logic [6:0]  duty;
		logic [15:0] amp, off;
		int          count, pause_at, phase_no;

		sb         = new();
		arst_n     = 1'b0;
		cfg_write  = 1'b0;
		cfg_index  = REG_WAVE_SHAPE;
		cfg_data   = '0;
		in_valid   = 1'b0;
		restart    = 1'b0;
		noise_word = '0;
		out_stall  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of every register
		send_tick(1'b0, 16'h0000);
		send_tick(1'b0, 16'hFFFF);
		settle();
		// sine at the quarter points, full gain clips both ends
		configure(SHAPE_SINE, 32'h4000_0000, 7'd50, 16'hFFFF, 16'h0000, 32'h0, 1'b0);
		burst(5, 1'b1, -1);
		// duty over 100 stays high, lowest offset pulls the code to zero
		configure(SHAPE_SQUARE, 32'h8000_0000, 7'd127, AMP_RESET, 16'h8000, 32'h0, 1'b0);
		burst(2, 1'b1, -1);
		configure(SHAPE_SQUARE, 32'h4000_0000, DUTY_MAX, 16'hFFFF, 16'h7FFF, 32'h0, 1'b0);
		burst(3, 1'b1, -1);
		// full step wraps the phase every tick
		configure(SHAPE_PULSE, 32'hFFFF_FFFF, 7'd0, 16'h0000, 16'h7FFF, 32'h0, 1'b0);
		burst(2, 1'b1, -1);
		configure(SHAPE_TRIANGLE, 32'h4000_0000, 7'd50, AMP_RESET, 16'h0000,
			32'hFFFF_FFFF, 1'b0);
		burst(3, 1'b1, -1);
		configure(SHAPE_SAWTOOTH, 32'h2000_0000, 7'd50, AMP_RESET, 16'h0000,
			32'h8000_0000, 1'b0);
		burst(2, 1'b1, -1);
		configure(SHAPE_NOISE, 32'h0, 7'd50, AMP_RESET, 16'h0000, 32'h0, 1'b0);
		send_tick(1'b0, 16'h0000);
		send_tick(1'b0, 16'hFFFF);
		send_tick(1'b1, 16'h8000);
		settle();
		// unused shapes give a zero sample, code from the offset alone
		configure(SHAPE_UNDEF_A, 32'h1234_5678, 7'd50, AMP_RESET, 16'h1000, 32'h0, 1'b1);
		burst(1, 1'b0, -1);
		configure(SHAPE_UNDEF_B, 32'h1234_5678, 7'd50, AMP_RESET, 16'hF000, 32'h0, 1'b1);
		burst(1, 1'b0, -1);

		phase_no = 0;
		while (sb.ticks < DIRECTED_TICKS + RANDOM_TICKS) begin
			phase_no++;
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			shape = ($urandom_range(0, 9) == 0)
			        ? ($urandom_range(0, 1) ? SHAPE_UNDEF_B : SHAPE_UNDEF_A)
			        : 3'($urandom_range(SHAPE_SINE, SHAPE_PULSE));
			case ($urandom_range(0, 5))
				0:       step = 32'h0;
				1:       step = 32'hFFFF_FFFF;
				2:       step = $urandom_range(1, 32'h00FF_FFFF);
				default: step = $urandom();
			endcase
			case ($urandom_range(0, 5))
				0:       duty = 7'd0;
				1:       duty = DUTY_MAX;
				2:       duty = 7'($urandom_range(101, 127));
				default: duty = 7'($urandom_range(0, 127));
			endcase
			case ($urandom_range(0, 5))
				0:       amp = 16'h0000;
				1:       amp = 16'hFFFF;
				2:       amp = AMP_RESET;
				default: amp = 16'($urandom_range(0, 8192));
			endcase
			case ($urandom_range(0, 6))
				0:       off = 16'h8000;
				1:       off = 16'h7FFF;
				2:       off = 16'h0000;
				3:       off = 16'($urandom());
				default: off = 16'($signed($urandom_range(0, 8192)) - 4096);
			endcase
			case ($urandom_range(0, 3))
				0:       start = 32'h0;
				1:       start = 32'hFFFF_FFFF;
				default: start = $urandom();
			endcase
			configure(shape, step, duty, amp, off, start, $urandom_range(0, 7) == 0);
			count = $urandom_range(20, 60);
			// receiver sits still while the sender keeps offering
			if (phase_no == 2 || $urandom_range(0, 9) == 0) begin
				long_hold_req = 1'b1;
				tx_idle_on    = 1'b0;
			end
			pause_at = (phase_no == 3 || $urandom_range(0, 4) == 0)
			           ? $urandom_range(1, count - 1) : -1;
			burst(count, $urandom_range(0, 1), pause_at);
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d ticks over %0d register settings, %0d samples compared",
			sb.ticks, n_settings, sb.checked);
		$display("%0d long receiver holds, %0d sender pauses, %0d mismatches",
			n_holds, n_pauses, sb.errors);
		if (sb.expected_q.size() != 0)
			$display("%0d ticks never produced a result", sb.expected_q.size());
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: dds_waveform_generator_top.f
rtl/core/dds_pkg.sv
rtl/core/dds_waveform_generator_top.sv
test/testbench.sv
